### design/whn_pkg.sv
// Shared types and constants for the weighted histogram normaliser.
// No dependencies; every other file of the block refers to it by scoped names.
package whn_pkg;

	localparam int METRIC_W = 20;
	localparam int WEIGHT_W = 24;
	localparam int BWIDTH_W = 19;
	localparam int SHARE_W  = 17;
	localparam int INDEX_W  = 6;
	localparam int MASK_W   = 3;
	localparam int MAX_MAPS = 3;
	localparam int DIV_STEPS = 17;

	localparam logic [SHARE_W-1:0] SHARE_ONE = 17'd65536;

	localparam int PADDR_W = 3;
	localparam logic [PADDR_W-1:0] REG_RANGE_LOW = 3'd0;
	localparam logic [PADDR_W-1:0] REG_BIN_WIDTH = 3'd4;

	localparam logic signed [METRIC_W-1:0] RANGE_LOW_RST = 20'sd655;
	localparam logic [BWIDTH_W-1:0] BIN_WIDTH_RST = 19'd7282;

	typedef enum logic [4:0] {
		S_RUN   = 5'b00001,
		S_DRAIN = 5'b00010,
		S_START = 5'b00100,
		S_DIV   = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

endpackage

### design/whn_in_if.sv
// Input channel of the weighted histogram normaliser: one voxel per transfer.
// Depends on whn_pkg for the field widths.
interface whn_in_if;
	logic valid;
	logic ready;
	logic in_roi;
	logic signed [whn_pkg::METRIC_W-1:0] metric;
	logic signed [whn_pkg::WEIGHT_W-1:0] beta_a;
	logic signed [whn_pkg::WEIGHT_W-1:0] beta_b;
	logic signed [whn_pkg::WEIGHT_W-1:0] beta_c;
	logic last;

	modport source (output valid, in_roi, metric, beta_a, beta_b, beta_c, last, input ready);
	modport sink (input valid, in_roi, metric, beta_a, beta_b, beta_c, last, output ready);
endinterface

### design/whn_out_if.sv
// Result channel of the weighted histogram normaliser: one bin per transfer.
// Depends on whn_pkg for the field widths.
interface whn_out_if;
	logic valid;
	logic ready;
	logic [whn_pkg::INDEX_W-1:0] bin_index;
	logic signed [whn_pkg::METRIC_W-1:0] bin_center;
	logic [whn_pkg::SHARE_W-1:0] share_a;
	logic [whn_pkg::SHARE_W-1:0] share_b;
	logic [whn_pkg::SHARE_W-1:0] share_c;
	logic [whn_pkg::MASK_W-1:0] zero_sum_mask;
	logic end_of_run;

	modport source (output valid, bin_index, bin_center, share_a, share_b, share_c,
		zero_sum_mask, end_of_run, input ready);
	modport sink (input valid, bin_index, bin_center, share_a, share_b, share_c,
		zero_sum_mask, end_of_run, output ready);
endinterface

### design/whn_bin_lane.sv
// One histogram bin: range test of the voxel and saturating per-map totals.
// Depends on whn_pkg; instantiated once per bin by the top level.
module whn_bin_lane #(
	parameter int LANE      = 0,
	parameter int NUM_MAPS  = 3,
	parameter int ACC_WIDTH = 48
) (
	input  logic clk,
	input  logic arst_n,
	input  logic sample,
	input  logic signed [whn_pkg::METRIC_W-1:0] metric_s1,
	input  logic signed [whn_pkg::METRIC_W-1:0] range_low,
	input  logic [whn_pkg::BWIDTH_W-1:0] bin_width,
	input  logic acc_en,
	input  logic [NUM_MAPS-1:0][whn_pkg::WEIGHT_W-1:0] weight_s2,
	input  logic shift_en,
	input  logic [NUM_MAPS-1:0][ACC_WIDTH-1:0] shift_in,
	output logic [NUM_MAPS-1:0][ACC_WIDTH-1:0] totals,
	output logic hit_s2
);

	logic signed [26:0] off;
	logic signed [26:0] lo;
	logic signed [26:0] hi;
	logic hit;
	logic [NUM_MAPS-1:0][ACC_WIDTH-1:0] tot_q;

	// Bin edges relative to range_low; the lane number is a constant factor.
	assign off = 27'(metric_s1) - 27'(range_low);
	assign lo  = $signed({2'b00, 25'(LANE) * 25'(bin_width)});
	assign hi  = $signed({2'b00, 25'(LANE + 1) * 25'(bin_width)});
	assign hit = sample && (off >= 27'sd0) && (off >= lo) && (off < hi);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s2 <= 1'b0;
		end else begin
			hit_s2 <= hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_q <= '0;
		end else if (shift_en) begin
			tot_q <= shift_in;
		end else if (acc_en && hit_s2) begin
			for (int m = 0; m < NUM_MAPS; m++) begin
				logic [ACC_WIDTH:0] s;
				s = {1'b0, tot_q[m]} + (ACC_WIDTH + 1)'(weight_s2[m]);
				tot_q[m] <= s[ACC_WIDTH] ? {ACC_WIDTH{1'b1}} : s[ACC_WIDTH-1:0];
			end
		end
	end

	assign totals = tot_q;

endmodule

### design/whn_share_div.sv
// Share unit: rounded bin total over map sum in Q1.16, one quotient bit a cycle.
// Depends on whn_pkg for the share width and the step count.
module whn_share_div #(
	parameter int ACC_WIDTH = 48,
	parameter int SUM_W     = 52
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [ACC_WIDTH-1:0] total,
	input  logic [SUM_W-1:0] sum,
	output logic done,
	output logic [whn_pkg::SHARE_W-1:0] share
);

	logic [SUM_W:0] r_q;
	logic [SUM_W-1:0] s_q;
	logic [whn_pkg::SHARE_W-1:0] q_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic zero_q;
	logic full_q;
	logic [SUM_W:0] r2;
	logic take;
	logic [whn_pkg::SHARE_W:0] rounded;

	assign r2   = {r_q[SUM_W-1:0], 1'b0};
	assign take = r2 >= {1'b0, s_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'(whn_pkg::DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q    <= (SUM_W + 1)'(total);
			s_q    <= sum;
			q_q    <= '0;
			zero_q <= (sum == '0);
			full_q <= (SUM_W'(total) >= sum);
		end else if (busy_q) begin
			r_q <= take ? (r2 - {1'b0, s_q}) : r2;
			q_q <= {q_q[whn_pkg::SHARE_W-2:0], take};
		end
	end

	assign rounded = ({1'b0, q_q} + 18'd1) >> 1;
	assign done    = done_q;
	assign share   = zero_q ? '0 : (full_q ? whn_pkg::SHARE_ONE : rounded[whn_pkg::SHARE_W-1:0]);

endmodule

### design/weighted_histogram_normalizer.sv
// Weighted histogram normaliser top level: lanes, map sums, readout and APB registers.
// Depends on whn_pkg, whn_in_if, whn_out_if, whn_bin_lane and whn_share_div.
//
// Voxels are taken one per cycle in the accumulation phase: each transfer is
// registered, every bin lane tests it against its own edges in the next cycle,
// and the matching lane adds the positive weights in the cycle after that, so
// the accumulation pipeline is two stages deep with no stall. A voxel marked
// last closes the run: input ready drops, the pipeline drains, and the block
// reads out NUM_BINS results in bin order. Each result passes through the share
// dividers, which produce one quotient bit a cycle (seventeen steps): a start
// state, the seventeen steps, a state in which the registered done flag is seen
// and the output register is loaded, and the output transfer itself. A stalled
// output adds its stall. The dividers for the maps run side by side. During
// readout the lanes shift their totals down by one bin per result, which also
// clears them; the map sums are cleared with the last transfer, after which
// voxels are taken again. Configuration (range_low at address 0, bin_width at
// address 4) is meant to be written only while no run is in progress.
module weighted_histogram_normalizer #(
	parameter int NUM_BINS  = 9,
	parameter int NUM_MAPS  = 3,
	parameter int ACC_WIDTH = 48
) (
	input  logic clk,
	input  logic arst_n,
	whn_in_if.sink in_ch,
	whn_out_if.source out_ch,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [whn_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam int SUM_W = (ACC_WIDTH + 4 > 64) ? 64 : ACC_WIDTH + 4;
	localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

	// Configuration registers.
	logic signed [whn_pkg::METRIC_W-1:0] range_low_q;
	logic [whn_pkg::BWIDTH_W-1:0] bin_width_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q <= whn_pkg::RANGE_LOW_RST;
			bin_width_q <= whn_pkg::BIN_WIDTH_RST;
		end else if (psel && penable && pwrite) begin
			if (paddr == whn_pkg::REG_RANGE_LOW) begin
				range_low_q <= pwdata[whn_pkg::METRIC_W-1:0];
			end
			if (paddr == whn_pkg::REG_BIN_WIDTH) begin
				bin_width_q <= pwdata[whn_pkg::BWIDTH_W-1:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		case (paddr)
			whn_pkg::REG_RANGE_LOW: prdata = 32'(range_low_q);
			whn_pkg::REG_BIN_WIDTH: prdata = 32'(bin_width_q);
			default: prdata = '0;
		endcase
	end

	// Control state.
	whn_pkg::state_t state_q;
	logic [BIN_W-1:0] bin_cnt_q;
	logic in_xfer;
	logic out_xfer;
	logic last_bin;

	assign in_ch.ready = (state_q == whn_pkg::S_RUN);
	assign in_xfer     = in_ch.valid && in_ch.ready;
	assign out_ch.valid = (state_q == whn_pkg::S_OUT);
	assign out_xfer    = out_ch.valid && out_ch.ready;
	assign last_bin    = (bin_cnt_q == BIN_W'(NUM_BINS - 1));

	// Stage one holds the voxel as received; stage two its masked weights.
	logic valid_s1, roi_s1, last_s1;
	logic signed [whn_pkg::METRIC_W-1:0] metric_s1;
	logic [whn_pkg::MAX_MAPS-1:0][whn_pkg::WEIGHT_W-1:0] beta_s1;
	logic valid_s2, last_s2;
	logic [NUM_MAPS-1:0][whn_pkg::WEIGHT_W-1:0] weight_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			last_s1  <= 1'b0;
			last_s2  <= 1'b0;
		end else begin
			valid_s1 <= in_xfer;
			last_s1  <= in_xfer && in_ch.last;
			valid_s2 <= valid_s1;
			last_s2  <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			roi_s1     <= in_ch.in_roi;
			metric_s1  <= in_ch.metric;
			beta_s1[0] <= in_ch.beta_a;
			beta_s1[1] <= in_ch.beta_b;
			beta_s1[2] <= in_ch.beta_c;
		end
		// Weights of zero or below count as nothing, so they are added as zero.
		for (int m = 0; m < NUM_MAPS; m++) begin
			weight_s2[m] <= ($signed(beta_s1[m]) > 0) ? beta_s1[m] : '0;
		end
	end

	// Bin lanes, chained so that readout shifts every total down by one bin.
	logic [NUM_MAPS-1:0][ACC_WIDTH-1:0] lane_tot [NUM_BINS];
	logic [NUM_BINS-1:0] lane_hit;
	logic shift_en;

	assign shift_en = out_xfer;

	for (genvar i = 0; i < NUM_BINS; i++) begin : g_lane
		logic [NUM_MAPS-1:0][ACC_WIDTH-1:0] feed;
		if (i == NUM_BINS - 1) begin : g_end
			assign feed = '0;
		end else begin : g_mid
			assign feed = lane_tot[i+1];
		end
		whn_bin_lane #(
			.LANE(i),
			.NUM_MAPS(NUM_MAPS),
			.ACC_WIDTH(ACC_WIDTH)
		) u_lane (
			.clk(clk),
			.arst_n(arst_n),
			.sample(valid_s1 && roi_s1),
			.metric_s1(metric_s1),
			.range_low(range_low_q),
			.bin_width(bin_width_q),
			.acc_en(valid_s2),
			.weight_s2(weight_s2),
			.shift_en(shift_en),
			.shift_in(feed),
			.totals(lane_tot[i]),
			.hit_s2(lane_hit[i])
		);
	end

	// Map sums grow whenever any lane takes the voxel.
	logic [NUM_MAPS-1:0][SUM_W-1:0] sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (out_xfer && last_bin) begin
			sum_q <= '0;
		end else if (valid_s2 && (|lane_hit)) begin
			for (int m = 0; m < NUM_MAPS; m++) begin
				logic [SUM_W:0] s;
				s = {1'b0, sum_q[m]} + (SUM_W + 1)'(weight_s2[m]);
				sum_q[m] <= s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
			end
		end
	end

	// Share dividers, one per map, all fed from the front lane.
	logic div_start;
	logic [NUM_MAPS-1:0] div_done;
	logic [whn_pkg::MAX_MAPS-1:0][whn_pkg::SHARE_W-1:0] share;
	logic [whn_pkg::MASK_W-1:0] zmask;

	assign div_start = (state_q == whn_pkg::S_START);

	for (genvar m = 0; m < whn_pkg::MAX_MAPS; m++) begin : g_map
		if (m < NUM_MAPS) begin : g_used
			whn_share_div #(
				.ACC_WIDTH(ACC_WIDTH),
				.SUM_W(SUM_W)
			) u_div (
				.clk(clk),
				.arst_n(arst_n),
				.start(div_start),
				.total(lane_tot[0][m]),
				.sum(sum_q[m]),
				.done(div_done[m]),
				.share(share[m])
			);
			assign zmask[m] = (sum_q[m] == '0);
		end else begin : g_unused
			assign share[m] = '0;
			assign zmask[m] = 1'b0;
		end
	end

	// Bin centre, saturated to the metric range.
	logic [24:0] centre_prod;
	logic signed [26:0] centre_raw;
	logic signed [whn_pkg::METRIC_W-1:0] centre;

	assign centre_prod = 25'(bin_cnt_q) * 25'(bin_width_q);
	assign centre_raw  = 27'(range_low_q) + $signed({2'b00, centre_prod})
		+ $signed({9'b0, bin_width_q[whn_pkg::BWIDTH_W-1:1]});

	always_comb begin
		if (centre_raw > 27'sd524287) begin
			centre = 20'sh7FFFF;
		end else if (centre_raw < -27'sd524288) begin
			centre = 20'sh80000;
		end else begin
			centre = centre_raw[whn_pkg::METRIC_W-1:0];
		end
	end

	// Readout sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= whn_pkg::S_RUN;
			bin_cnt_q <= '0;
		end else begin
			case (state_q)
				whn_pkg::S_RUN: begin
					if (in_xfer && in_ch.last) begin
						state_q <= whn_pkg::S_DRAIN;
					end
				end
				whn_pkg::S_DRAIN: begin
					if (valid_s2 && last_s2) begin
						state_q <= whn_pkg::S_START;
					end
				end
				whn_pkg::S_START: state_q <= whn_pkg::S_DIV;
				whn_pkg::S_DIV: begin
					if (div_done[0]) begin
						state_q <= whn_pkg::S_OUT;
					end
				end
				whn_pkg::S_OUT: begin
					if (out_xfer) begin
						if (last_bin) begin
							bin_cnt_q <= '0;
							state_q   <= whn_pkg::S_RUN;
						end else begin
							bin_cnt_q <= bin_cnt_q + BIN_W'(1);
							state_q   <= whn_pkg::S_START;
						end
					end
				end
				default: state_q <= whn_pkg::S_RUN;
			endcase
		end
	end

	// Output register, loaded once the shares of the current bin are ready.
	logic [whn_pkg::INDEX_W-1:0] idx_q;
	logic signed [whn_pkg::METRIC_W-1:0] centre_q;
	logic [whn_pkg::MAX_MAPS-1:0][whn_pkg::SHARE_W-1:0] share_q;
	logic [whn_pkg::MASK_W-1:0] zmask_q;
	logic eor_q;

	always_ff @(posedge clk) begin
		if ((state_q == whn_pkg::S_DIV) && div_done[0]) begin
			idx_q    <= whn_pkg::INDEX_W'(bin_cnt_q);
			centre_q <= centre;
			share_q  <= share;
			zmask_q  <= zmask;
			eor_q    <= last_bin;
		end
	end

	assign out_ch.bin_index     = idx_q;
	assign out_ch.bin_center    = centre_q;
	assign out_ch.share_a       = share_q[0];
	assign out_ch.share_b       = share_q[1];
	assign out_ch.share_c       = share_q[2];
	assign out_ch.zero_sum_mask = zmask_q;
	assign out_ch.end_of_run    = eor_q;

endmodule

### tb/testbench.sv
// Self-checking testbench for the weighted histogram normaliser.
// Depends on whn_pkg, whn_in_if, whn_out_if and the weighted_histogram_normalizer RTL.
module testbench;

	localparam int BINS      = 9;
	localparam int MAPS      = 3;
	localparam int ACC_W     = 48;
	localparam int SUM_W     = ACC_W + 4;
	localparam int SETTLE    = 40;

	// One predicted bin of a readout.
	typedef struct {
		logic [whn_pkg::INDEX_W-1:0]         bin_index;
		logic signed [whn_pkg::METRIC_W-1:0] bin_center;
		logic [whn_pkg::SHARE_W-1:0]         share [MAPS];
		logic [whn_pkg::MASK_W-1:0]          zero_sum_mask;
		logic                                end_of_run;
	} bin_result_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [whn_pkg::PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	whn_in_if  vin ();
	whn_out_if vout ();

	weighted_histogram_normalizer u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (vin.sink),
		.out_ch  (vout.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow copy of the block: its registers and its accumulators.
	logic signed [whn_pkg::METRIC_W-1:0] cfg_range_low;
	logic [whn_pkg::BWIDTH_W-1:0]        cfg_bin_width;
	logic [ACC_W-1:0]                    bin_totals [BINS][MAPS];
	logic [SUM_W-1:0]                    map_sums [MAPS];

	bin_result_t pending_bins [$];
	int  errors;
	bit  src_quiet;
	bit  sink_quiet;
	int  sink_stall = 0;

	always #5 clk = ~clk;

	initial begin
		#10000000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Rounded share of a bin total in its map sum, ties going up, clamped to one.
	function automatic logic [whn_pkg::SHARE_W-1:0] share_of(input logic [ACC_W-1:0] t,
			input logic [SUM_W-1:0] s);
		logic [127:0] q;
		if (t >= s)
			return whn_pkg::SHARE_ONE;
		q = ({80'd0, t} << 17) / {76'd0, s};
		q = (q + 1) >> 1;
		if (q > 128'd65536)
			return whn_pkg::SHARE_ONE;
		return q[whn_pkg::SHARE_W-1:0];
	endfunction

	function automatic void clear_accumulators();
		for (int i = 0; i < BINS; i++)
			for (int m = 0; m < MAPS; m++)
				bin_totals[i][m] = '0;
		for (int m = 0; m < MAPS; m++)
			map_sums[m] = '0;
	endfunction

	// Adds one accepted voxel to the shadow histogram and, on the last voxel of a run,
	// queues the readout that the block must produce.
	function automatic void bin_voxel(input logic roi,
			input logic signed [whn_pkg::METRIC_W-1:0] metric,
			input logic signed [whn_pkg::WEIGHT_W-1:0] w [MAPS], input logic last);
		longint off;
		longint idx;
		longint c;
		logic [whn_pkg::MASK_W-1:0] zmask;
		bin_result_t r;
		if (roi && cfg_bin_width != 0) begin
			off = longint'(metric) - longint'(cfg_range_low);
			if (off >= 0) begin
				idx = off / longint'(cfg_bin_width);
				if (idx < BINS) begin
					for (int m = 0; m < MAPS; m++) begin
						if (w[m] > 0) begin
							// Saturating adds; the widths leave room for the carry.
							if ({1'b0, bin_totals[idx][m]} + ACC_W'(w[m]) > {1'b0, {ACC_W{1'b1}}})
								bin_totals[idx][m] = {ACC_W{1'b1}};
							else
								bin_totals[idx][m] = bin_totals[idx][m] + ACC_W'(w[m]);
							if ({1'b0, map_sums[m]} + SUM_W'(w[m]) > {1'b0, {SUM_W{1'b1}}})
								map_sums[m] = {SUM_W{1'b1}};
							else
								map_sums[m] = map_sums[m] + SUM_W'(w[m]);
						end
					end
				end
			end
		end
		if (!last)
			return;
		zmask = '0;
		for (int m = 0; m < MAPS; m++)
			if (map_sums[m] == 0)
				zmask[m] = 1'b1;
		for (int i = 0; i < BINS; i++) begin
			c = longint'(cfg_range_low) + longint'(i) * longint'(cfg_bin_width)
				+ longint'(cfg_bin_width >> 1);
			if (c > 524287)
				c = 524287;
			if (c < -524288)
				c = -524288;
			r.bin_index = whn_pkg::INDEX_W'(i);
			r.bin_center = whn_pkg::METRIC_W'(c);
			for (int m = 0; m < MAPS; m++)
				r.share[m] = (map_sums[m] == 0) ? '0 : share_of(bin_totals[i][m], map_sums[m]);
			r.zero_sum_mask = zmask;
			r.end_of_run = (i == BINS - 1);
			pending_bins.push_back(r);
		end
		clear_accumulators();
	endfunction

	// Sends one voxel after a random gap and predicts its effect once the transfer is taken.
	task automatic send_voxel(input logic roi, input logic signed [whn_pkg::METRIC_W-1:0] metric,
			input logic signed [whn_pkg::WEIGHT_W-1:0] wa,
			input logic signed [whn_pkg::WEIGHT_W-1:0] wb,
			input logic signed [whn_pkg::WEIGHT_W-1:0] wc, input logic last);
		int gap;
		logic signed [whn_pkg::WEIGHT_W-1:0] w [MAPS];
		gap = src_quiet ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			@(negedge clk);
			vin.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		vin.valid  <= 1'b1;
		vin.in_roi <= roi;
		vin.metric <= metric;
		vin.beta_a <= wa;
		vin.beta_b <= wb;
		vin.beta_c <= wc;
		vin.last   <= last;
		do @(posedge clk); while (!vin.ready);
		w[0] = wa;
		w[1] = wb;
		w[2] = wc;
		bin_voxel(roi, metric, w, last);
	endtask

	// Lowers valid and waits until every queued bin has arrived and the pipeline has emptied.
	task automatic wait_idle();
		@(negedge clk);
		vin.valid <= 1'b0;
		while (pending_bins.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle; the register takes the data at its end.
	task automatic reg_write(input logic [whn_pkg::PADDR_W-1:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == whn_pkg::REG_RANGE_LOW)
			cfg_range_low = data[whn_pkg::METRIC_W-1:0];
		else
			cfg_bin_width = data[whn_pkg::BWIDTH_W-1:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// APB read with a check of the register bits against the shadow copy.
	task automatic reg_check(input logic [whn_pkg::PADDR_W-1:0] addr);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == whn_pkg::REG_RANGE_LOW
				&& prdata[whn_pkg::METRIC_W-1:0] !== cfg_range_low) begin
			$error("range_low: expected %0d, actual %0d", cfg_range_low,
				prdata[whn_pkg::METRIC_W-1:0]);
			errors++;
		end
		if (addr == whn_pkg::REG_BIN_WIDTH
				&& prdata[whn_pkg::BWIDTH_W-1:0] !== cfg_bin_width) begin
			$error("bin_width: expected %0d, actual %0d", cfg_bin_width,
				prdata[whn_pkg::BWIDTH_W-1:0]);
			errors++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_bins(input logic signed [whn_pkg::METRIC_W-1:0] low,
			input logic [whn_pkg::BWIDTH_W-1:0] w);
		reg_write(whn_pkg::REG_RANGE_LOW, 32'(low));
		reg_write(whn_pkg::REG_BIN_WIDTH, 32'(w));
		reg_check(whn_pkg::REG_RANGE_LOW);
		reg_check(whn_pkg::REG_BIN_WIDTH);
	endtask

	// Random weight: mostly positive, sometimes negative or zero.
	function automatic logic signed [whn_pkg::WEIGHT_W-1:0] rand_weight();
		int p;
		p = $urandom_range(0, 99);
		if (p < 70)
			return whn_pkg::WEIGHT_W'($urandom_range(1, 8388607));
		if (p < 85)
			return whn_pkg::WEIGHT_W'(-$signed($urandom_range(1, 8388608)));
		return '0;
	endfunction

	// Random metric: mostly inside the configured range, the rest anywhere in the field.
	function automatic logic signed [whn_pkg::METRIC_W-1:0] rand_metric();
		longint span;
		longint v;
		span = longint'(cfg_bin_width) * BINS;
		if ($urandom_range(0, 99) < 80 && span > 0) begin
			v = longint'(cfg_range_low) + longint'($urandom_range(0, 32'(span - 1)));
			if (v > 524287)
				v = 524287;
			return whn_pkg::METRIC_W'(v);
		end
		return whn_pkg::METRIC_W'($urandom);
	endfunction

	// Reset values, the edges of the range and the extremes of the weights.
	task automatic test_reset_bins();
		reg_check(whn_pkg::REG_RANGE_LOW);
		reg_check(whn_pkg::REG_BIN_WIDTH);
		send_voxel(1'b1, 20'sd655, 24'sd8388607, 24'sd1, 24'sd0, 1'b0);
		send_voxel(1'b1, 20'sd66192, 24'sd100000, -24'sd8388608, 24'sd65536, 1'b0);
		send_voxel(1'b1, 20'sd654, 24'sd500000, 24'sd500000, 24'sd500000, 1'b0);
		send_voxel(1'b1, 20'sd66193, 24'sd500000, 24'sd500000, 24'sd500000, 1'b0);
		send_voxel(1'b0, 20'sd7000, 24'sd500000, 24'sd500000, 24'sd500000, 1'b0);
		send_voxel(1'b1, 20'sd7937, -24'sd1, 24'sd300, 24'sd8388607, 1'b0);
		send_voxel(1'b1, 20'sd30000, 24'sd1, 24'sd2, 24'sd3, 1'b1);
		wait_idle();
	endtask

	// A run in which nothing counts, so every map sum stays zero, then a run with one empty map.
	task automatic test_empty_run();
		send_voxel(1'b0, 20'sd1000, 24'sd1000, 24'sd1000, 24'sd1000, 1'b0);
		send_voxel(1'b1, -20'sd524288, 24'sd1000, 24'sd1000, 24'sd1000, 1'b0);
		send_voxel(1'b1, 20'sd20000, -24'sd5, 24'sd0, -24'sd8388608, 1'b1);
		// One map empty, the others not.
		send_voxel(1'b1, 20'sd20000, 24'sd7, 24'sd0, 24'sd9, 1'b1);
		wait_idle();
	endtask

	// Widest bins from the bottom of the field, then unit bins at its top; centres saturate.
	task automatic test_extreme_bins();
		set_bins(-20'sd524288, 19'd524287);
		send_voxel(1'b1, -20'sd524288, 24'sd8388607, 24'sd8388607, 24'sd8388607, 1'b0);
		send_voxel(1'b1, 20'sd524287, 24'sd1, 24'sd4096, 24'sd8388607, 1'b0);
		send_voxel(1'b1, 20'sd0, 24'sd123456, 24'sd1, 24'sd77, 1'b1);
		wait_idle();
		set_bins(20'sd524287, 19'd1);
		send_voxel(1'b1, 20'sd524287, 24'sd5, 24'sd6, 24'sd7, 1'b0);
		send_voxel(1'b1, 20'sd524286, 24'sd5, 24'sd6, 24'sd7, 1'b1);
		wait_idle();
	endtask

	// A zero bin width matches no bin, so every voxel is ignored.
	task automatic test_zero_width();
		set_bins(20'sd0, 19'd0);
		send_voxel(1'b1, 20'sd0, 24'sd100, 24'sd100, 24'sd100, 1'b0);
		send_voxel(1'b1, 20'sd5, 24'sd100, 24'sd100, 24'sd100, 1'b1);
		wait_idle();
	endtask

	// Random runs of voxels under random bin settings, with random idling on both sides.
	task automatic test_random_runs();
		int sent;
		int run_len;
		sent = 0;
		while (sent < 260) begin
			if ($urandom_range(0, 3) == 0) begin
				wait_idle();
				if ($urandom_range(0, 1) == 0)
					set_bins(whn_pkg::METRIC_W'($urandom),
						whn_pkg::BWIDTH_W'($urandom_range(1, 524287)));
				else
					set_bins(whn_pkg::METRIC_W'(-$signed($urandom_range(0, 400000))),
						whn_pkg::BWIDTH_W'($urandom_range(1, 4000)));
			end
			src_quiet  = ($urandom_range(0, 4) == 0);
			sink_quiet = ($urandom_range(0, 4) == 0);
			run_len = $urandom_range(1, 30);
			for (int k = 0; k < run_len; k++) begin
				send_voxel($urandom_range(0, 99) < 85, rand_metric(), rand_weight(),
					rand_weight(), rand_weight(), k == run_len - 1);
				sent++;
			end
			// Now and then hold off until the whole readout has come back.
			if ($urandom_range(0, 3) == 0) begin
				@(negedge clk);
				vin.valid <= 1'b0;
				while (pending_bins.size() != 0) @(posedge clk);
			end
		end
		src_quiet  = 1'b0;
		sink_quiet = 1'b0;
		wait_idle();
	endtask

	// Result side: ready stays low while a stall drawn after a transfer runs down.
	always @(negedge clk) begin
		vout.ready <= (sink_stall == 0);
	end

	always @(posedge clk) begin
		bin_result_t e;
		if (arst_n && vout.valid && vout.ready) begin
			sink_stall <= sink_quiet ? 0 : $urandom_range(0, 9);
			if (pending_bins.size() == 0) begin
				$error("bin transfer with no bin expected");
				errors++;
			end else begin
				e = pending_bins.pop_front();
				if (vout.bin_index !== e.bin_index) begin
					$error("bin_index: expected %0d, actual %0d", e.bin_index, vout.bin_index);
					errors++;
				end
				if (vout.bin_center !== e.bin_center) begin
					$error("bin_center: expected %0d, actual %0d", e.bin_center, vout.bin_center);
					errors++;
				end
				if (vout.share_a !== e.share[0]) begin
					$error("share_a: expected %0d, actual %0d", e.share[0], vout.share_a);
					errors++;
				end
				if (vout.share_b !== e.share[1]) begin
					$error("share_b: expected %0d, actual %0d", e.share[1], vout.share_b);
					errors++;
				end
				if (vout.share_c !== e.share[2]) begin
					$error("share_c: expected %0d, actual %0d", e.share[2], vout.share_c);
					errors++;
				end
				if (vout.zero_sum_mask !== e.zero_sum_mask) begin
					$error("zero_sum_mask: expected %0d, actual %0d", e.zero_sum_mask,
						vout.zero_sum_mask);
					errors++;
				end
				if (vout.end_of_run !== e.end_of_run) begin
					$error("end_of_run: expected %0d, actual %0d", e.end_of_run, vout.end_of_run);
					errors++;
				end
			end
		end else if (sink_stall > 0) begin
			sink_stall <= sink_stall - 1;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		vin.valid = 1'b0;
		vin.in_roi = 1'b0;
		vin.metric = '0;
		vin.beta_a = '0;
		vin.beta_b = '0;
		vin.beta_c = '0;
		vin.last = 1'b0;
		errors = 0;
		src_quiet = 1'b0;
		sink_quiet = 1'b0;
		cfg_range_low = whn_pkg::RANGE_LOW_RST;
		cfg_bin_width = whn_pkg::BIN_WIDTH_RST;
		clear_accumulators();
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_bins();
		test_empty_run();
		test_extreme_bins();
		test_zero_width();
		test_random_runs();

		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
